// ===== design/rc4_pkg.sv =====
`timescale 1ns / 1ps

package rc4_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int BYTE_W      = 8;
    localparam logic [BYTE_W-1:0] KEY_RESET = 8'h5A;
    localparam logic [BYTE_W-1:0] CNT_LAST  = 8'hFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in_message;
    } t_in_item;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       last_out;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_KRD_N,
        S_KRD_ACC,
        S_KWR1,
        S_KWR2,
        S_PRD_I,
        S_PRD_J,
        S_PWR1,
        S_PWR2,
        S_PRD_K,
        S_POUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_FILL,
        OP_KRD_N,
        OP_KRD_ACC,
        OP_KWR1,
        OP_KWR2,
        OP_PRD_I,
        OP_PRD_J,
        OP_PWR1,
        OP_PWR2,
        OP_PRD_K,
        OP_POUT
    } t_op;

    typedef struct packed {
        logic capture;
        logic sched_start;
        logic sched_done;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic cnt_last;
        logic item_last;
        logic out_free;
    } t_sts;

endpackage

// ===== design/rc4_ram.sv =====
`timescale 1ns / 1ps

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/rc4_ctrl.sv =====
`timescale 1ns / 1ps

module rc4_ctrl import rc4_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall
);

    t_state r_state, n_state;
    logic   r_need, n_need;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_need  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_need  <= n_need;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_need  = r_need;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = r_need ? S_FILL : S_PRD_I;
                end
            end
            S_FILL: begin
                if (i_sts.cnt_last) begin
                    n_state = S_KRD_N;
                end
            end
            S_KRD_N:   n_state = S_KRD_ACC;
            S_KRD_ACC: n_state = S_KWR1;
            S_KWR1:    n_state = S_KWR2;
            S_KWR2: begin
                if (i_sts.cnt_last) begin
                    n_state = S_PRD_I;
                    n_need  = 1'b0;
                end else begin
                    n_state = S_KRD_N;
                end
            end
            S_PRD_I: n_state = S_PRD_J;
            S_PRD_J: n_state = S_PWR1;
            S_PWR1:  n_state = S_PWR2;
            S_PWR2:  n_state = S_PRD_K;
            S_PRD_K: n_state = S_POUT;
            S_POUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                    if (i_sts.item_last) begin
                        n_need = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_cmd.op    = OP_NONE;
        o_in_stall  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall        = 1'b0;
                o_cmd.capture     = i_in_valid;
                o_cmd.sched_start = i_in_valid && r_need;
            end
            S_FILL:    o_cmd.op = OP_FILL;
            S_KRD_N:   o_cmd.op = OP_KRD_N;
            S_KRD_ACC: o_cmd.op = OP_KRD_ACC;
            S_KWR1:    o_cmd.op = OP_KWR1;
            S_KWR2: begin
                o_cmd.op         = OP_KWR2;
                o_cmd.sched_done = i_sts.cnt_last;
            end
            S_PRD_I: o_cmd.op = OP_PRD_I;
            S_PRD_J: o_cmd.op = OP_PRD_J;
            S_PWR1:  o_cmd.op = OP_PWR1;
            S_PWR2:  o_cmd.op = OP_PWR2;
            S_PRD_K: o_cmd.op = OP_PRD_K;
            S_POUT:  o_cmd.op = OP_POUT;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== design/rc4_dpath.sv =====
`timescale 1ns / 1ps

module rc4_dpath import rc4_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  t_in_item    i_in_item,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_item
);

    logic [7:0] r_key;
    logic [7:0] r_cnt, n_cnt;
    logic [7:0] r_acc, n_acc;
    logic [7:0] r_i, n_i;
    logic [7:0] r_j, n_j;
    logic [7:0] r_a, n_a;
    logic [7:0] r_b, n_b;
    t_in_item   r_item;
    t_out_item  r_out;
    logic       r_out_valid;

    logic       ram_we;
    logic [7:0] ram_waddr;
    logic [7:0] ram_wdata;
    logic [7:0] ram_raddr;
    logic [7:0] ram_rdata;
    logic       out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    rc4_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(TABLE_DEPTH)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_i       = r_i;
        n_j       = r_j;
        n_a       = r_a;
        n_b       = r_b;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        case (i_cmd.op)
            OP_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = r_cnt;
                n_cnt     = 8'(r_cnt + 8'd1);
            end
            OP_KRD_N: ram_raddr = r_cnt;
            OP_KRD_ACC: begin
                n_acc     = 8'(r_acc + ram_rdata + r_key);
                n_a       = ram_rdata;
                ram_raddr = n_acc;
            end
            OP_KWR1: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = ram_rdata;
            end
            OP_KWR2: begin
                ram_we    = 1'b1;
                ram_waddr = r_acc;
                ram_wdata = r_a;
                n_cnt     = 8'(r_cnt + 8'd1);
            end
            OP_PRD_I: begin
                n_i       = 8'(r_i + 8'd1);
                ram_raddr = n_i;
            end
            OP_PRD_J: begin
                n_j       = 8'(r_j + ram_rdata);
                n_a       = ram_rdata;
                ram_raddr = n_j;
            end
            OP_PWR1: begin
                ram_we    = 1'b1;
                ram_waddr = r_i;
                ram_wdata = ram_rdata;
                n_b       = ram_rdata;
            end
            OP_PWR2: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = r_a;
            end
            OP_PRD_K: ram_raddr = 8'(r_a + r_b);
            OP_POUT:  ram_raddr = 8'(r_a + r_b);
            default: ;
        endcase
        if (i_cmd.sched_start) begin
            n_cnt = '0;
            n_acc = '0;
        end
        if (i_cmd.sched_done) begin
            n_i = '0;
            n_j = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= KEY_RESET;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_key <= i_cfg_wdata;
            end
            r_i <= n_i;
            r_j <= n_j;
            if (i_cmd.op == OP_POUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
        if (i_cmd.op == OP_POUT && out_free) begin
            r_out.result_byte <= r_item.data_byte ^ ram_rdata;
            r_out.last_out    <= r_item.last_in_message;
        end
    end

    assign o_sts.cnt_last  = (r_cnt == CNT_LAST);
    assign o_sts.item_last = r_item.last_in_message;
    assign o_sts.out_free  = out_free;
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out;

endmodule

// ===== design/rc4_stream_cipher.sv =====
`timescale 1ns / 1ps
// RC4 stream cipher, one-byte key. Encrypt and decrypt are the same operation.
// Input channel: i_in_valid / o_in_stall carry one message byte plus a flag
// that marks the last byte of the message. Output channel: o_out_valid /
// i_out_stall carry the XORed byte and a copy of that flag, one per input.
// Key: i_cfg_we writes i_cfg_wdata into the key register (reset 0x5A); write
// it only while the block is idle. It is used by the next key schedule.
// Timing: a byte is accepted when the block is idle and steps through PRD_I,
// PRD_J, PWR1, PWR2, PRD_K, POUT; the next is taken only back in idle.
// Every step goes through the single-port-read permutation RAM (one read,
// one write per cycle, registered read).
// The first byte of each message first rebuilds the table: an identity fill
// of all 256 entries, then the key schedule that swaps each entry in turn.
// Reset clears the indices, the output valid and sets the schedule pending;
// the table itself is not cleared. A stalled result stays in the output
// register; the block still takes the next byte and works on it, holding
// it only at the final output step until the register frees.
module rc4_stream_cipher import rc4_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    rc4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    rc4_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== design/rc4_checker.sv =====
`timescale 1ns / 1ps

module rc4_checker import rc4_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input t_out_item  o_out_item
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall ##1 o_in_stall ##1 o_in_stall ##1 o_in_stall
                   ##1 o_in_stall ##1 o_in_stall)
        else $error("item accepted while previous item in flight");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);
